FILE: design/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

    typedef enum logic [2:0] {
        FN_TICK    = 3'd0,
        FN_SPAWN   = 3'd1,
        FN_TERM    = 3'd2,
        FN_SUSPEND = 3'd3,
        FN_RESUME  = 3'd4,
        FN_SLEEP   = 3'd5,
        FN_QUERY   = 3'd6
    } func_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_THR   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_MAIN     = 3'd3;
    localparam logic [2:0] ST_BAD_CNT  = 3'd4;
    localparam logic [2:0] ST_HALTED   = 3'd5;

    typedef enum logic [1:0] {
        MODE_READY     = 2'd0,
        MODE_RUNNING   = 2'd1,
        MODE_SUSPENDED = 2'd2,
        MODE_SLEEPING  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RM_WAIT,
        S_FREE,
        S_QRD,
        S_HO_INC,
        S_HO_SCAN,
        S_HO_REQ,
        S_HO_POP,
        S_HO_POPW,
        S_HO_QRD,
        S_HO_QWR,
        S_DONE
    } sched_state_t;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_SRCH_RD,
        Q_SRCH_CMP,
        Q_HEAD,
        Q_SHF_RD,
        Q_SHF_WR
    } q_state_t;

    typedef struct packed {
        logic push;
        logic remove;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic done;
        logic empty;
    } q_sts_t;

    typedef struct packed {
        logic q_we;
        logic w_we;
    } tbl_wr_t;

endpackage

FILE: design/rrts_if.sv
`timescale 1ns / 1ps

interface rrts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [3:0]  thread_id;
    logic [15:0] sleep_quanta;

    modport source (output valid, output func, output thread_id, output sleep_quanta,
                    input ready);
    modport sink (input valid, input func, input thread_id, input sleep_quanta,
                  output ready);
endinterface

interface rrts_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value;
    logic [3:0]  running_thread;
    logic [31:0] total_quanta;

    modport source (output valid, output status, output value, output running_thread,
                    output total_quanta, input ready);
    modport sink (input valid, input status, input value, input running_thread,
                  input total_quanta, output ready);
endinterface

FILE: design/rrts_table.sv
`timescale 1ns / 1ps

module rrts_table
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = 16,
    localparam int IDW = $clog2(MAX_THREADS)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [IDW-1:0] rd_addr,
    input  tbl_wr_t        wr,
    input  logic [IDW-1:0] wr_addr,
    input  logic [31:0]    q_wdata,
    input  logic [31:0]    w_wdata,
    output logic [31:0]    rd_quanta,
    output logic [31:0]    rd_wake
);

    typedef struct packed {
        logic [31:0] quanta;
        logic [31:0] wake;
    } tbl_entry_t;

    tbl_entry_t tbl_mem [MAX_THREADS];
    tbl_entry_t rd_data_reg;
    logic       q0_init_reg;
    logic       rd_q0_reg;

    // Entry zero holds one quantum after reset until its count is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_init_reg <= 1'b1;
            rd_q0_reg   <= 1'b0;
        end
        else
        begin
            if (wr.q_we && wr_addr == '0)
            begin
                q0_init_reg <= 1'b0;
            end
            rd_q0_reg <= q0_init_reg && rd_addr == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.q_we)
        begin
            tbl_mem[wr_addr].quanta <= q_wdata;
        end
        if (wr.w_we)
        begin
            tbl_mem[wr_addr].wake <= w_wdata;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    assign rd_quanta = rd_q0_reg ? 32'd1 : rd_data_reg.quanta;
    assign rd_wake   = rd_data_reg.wake;

endmodule

FILE: design/rrts_queue.sv
`timescale 1ns / 1ps

module rrts_queue
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = 16,
    localparam int IDW = $clog2(MAX_THREADS),
    localparam int CW  = $clog2(MAX_THREADS + 1)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  q_ctl_t         ctl,
    input  logic [IDW-1:0] id,
    output q_sts_t         sts,
    output logic [IDW-1:0] head
);

    localparam logic [CW-1:0] DEPTH = CW'(MAX_THREADS);

    logic [IDW-1:0] fifo_mem [MAX_THREADS];
    logic [IDW-1:0] rd_data_reg;
    q_state_t       state_reg;
    q_state_t       state_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  idx_reg;
    logic [IDW-1:0] target_reg;
    logic [IDW-1:0] head_reg;
    logic [CW-1:0]  idx_p1;
    logic [IDW-1:0] rd_addr;
    logic           wr_en;
    logic [IDW-1:0] wr_addr;
    logic [IDW-1:0] wr_data;
    logic           srch_end;
    logic           shf_end;

    assign idx_p1   = idx_reg + CW'(1);
    assign srch_end = idx_reg >= cnt_reg;
    assign shf_end  = idx_p1 >= cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (ctl.remove)
                begin
                    state_next = Q_SRCH_RD;
                end
                else if (ctl.pop)
                begin
                    state_next = Q_HEAD;
                end
            end
            Q_SRCH_RD:  state_next = srch_end ? Q_IDLE : Q_SRCH_CMP;
            Q_SRCH_CMP: state_next = (rd_data_reg == target_reg) ? Q_SHF_RD : Q_SRCH_RD;
            Q_HEAD:     state_next = Q_SHF_RD;
            Q_SHF_RD:   state_next = shf_end ? Q_IDLE : Q_SHF_WR;
            Q_SHF_WR:   state_next = Q_SHF_RD;
            default:    state_next = Q_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = id;
        sts.done  = 1'b0;
        sts.empty = cnt_reg == '0;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (ctl.push && cnt_reg < DEPTH)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[IDW-1:0];
                end
            end
            Q_SRCH_RD:
            begin
                rd_addr  = idx_reg[IDW-1:0];
                sts.done = srch_end;
            end
            Q_SHF_RD:
            begin
                rd_addr  = idx_p1[IDW-1:0];
                sts.done = shf_end;
            end
            Q_SHF_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IDW-1:0];
                wr_data = rd_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == Q_IDLE && ctl.push && cnt_reg < DEPTH)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (state_reg == Q_SHF_RD && shf_end)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            Q_IDLE:
            begin
                target_reg <= id;
                idx_reg    <= '0;
            end
            Q_SRCH_CMP:
            begin
                if (rd_data_reg != target_reg)
                begin
                    idx_reg <= idx_p1;
                end
            end
            Q_HEAD:
            begin
                head_reg <= rd_data_reg;
                idx_reg  <= '0;
            end
            Q_SHF_WR: idx_reg <= idx_p1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= fifo_mem[rd_addr];
    end

    assign head = head_reg;

endmodule

FILE: design/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   func, thread_id, sleep_quanta
// rsp      out  valid/ready   status, value, running_thread, total_quanta
//
// One request at a time, one response each; a query adds a table read and a spawn
// steps over the ids in use. A queue removal searches and shifts the Q queued threads;
// a handoff scans all MAX_THREADS ids and pops the queue head, each step held to
// the single read ports of the table and queue memories.
// A new request is taken while the previous response waits on a stalled rsp.
// Reset leaves thread 0 running with one quantum and the total count at one.

module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = 16
)
(
    input logic         clk,
    input logic         rst_n,
    rrts_req_if.sink    req,
    rrts_rsp_if.source  rsp
);

    localparam int IDW = $clog2(MAX_THREADS);
    localparam int CW  = $clog2(MAX_THREADS + 1);
    localparam int XW  = IDW + 5;
    localparam logic [CW-1:0] NCNT = CW'(MAX_THREADS);
    localparam logic [XW-1:0] NEXT = XW'(MAX_THREADS);

    sched_state_t   state_reg;
    sched_state_t   state_next;
    logic           valid_reg [MAX_THREADS];
    mode_t          mode_reg [MAX_THREADS];
    logic [IDW-1:0] cur_reg;
    logic [31:0]    total_reg;
    logic [CW-1:0]  lfree_reg;
    logic [CW-1:0]  live_reg;
    logic           halted_reg;
    logic [2:0]     func_reg;
    logic [3:0]     tid_reg;
    logic [15:0]    nq_reg;
    logic [2:0]     status_reg;
    logic [31:0]    value_reg;
    logic           ho_pend_reg;
    logic           requeue_reg;
    logic [CW-1:0]  scan_reg;
    logic           cand_reg;
    logic [IDW-1:0] cidx_reg;
    logic           out_v_reg;
    logic [2:0]     out_status_reg;
    logic [31:0]    out_value_reg;
    logic [3:0]     out_run_reg;
    logic [31:0]    out_total_reg;

    q_ctl_t         q_ctl;
    q_sts_t         q_sts;
    logic [IDW-1:0] q_id;
    logic [IDW-1:0] q_head;
    logic [IDW-1:0] tbl_rd_addr;
    tbl_wr_t        tbl_wr;
    logic [IDW-1:0] tbl_wr_addr;
    logic [31:0]    tbl_q_wdata;
    logic [31:0]    tbl_w_wdata;
    logic [31:0]    tbl_quanta;
    logic [31:0]    tbl_wake;

    logic [XW-1:0]  tid_ext;
    logic [IDW-1:0] tid_idx;
    logic [XW-1:0]  cur_ext;
    logic           exists;
    mode_t          tid_mode;
    logic           scan_live;
    logic           wake_hit;
    logic           out_free;
    logic [2:0]     dec_status;
    logic           act_tick;
    logic           act_spawn;
    logic           act_halt;
    logic           act_term;
    logic           act_susp;
    logic           act_resume;
    logic           act_sleep;
    logic           act_query;

    assign tid_ext   = XW'(tid_reg);
    assign tid_idx   = tid_ext[IDW-1:0];
    assign cur_ext   = XW'(cur_reg);
    assign exists    = tid_ext < NEXT && valid_reg[tid_idx];
    assign tid_mode  = mode_reg[tid_idx];
    assign scan_live = scan_reg < NCNT;
    assign wake_hit  = cand_reg && tbl_wake == total_reg;
    assign out_free  = !out_v_reg || rsp.ready;

    always_comb
    begin
        dec_status = ST_OK;
        act_tick   = 1'b0;
        act_spawn  = 1'b0;
        act_halt   = 1'b0;
        act_term   = 1'b0;
        act_susp   = 1'b0;
        act_resume = 1'b0;
        act_sleep  = 1'b0;
        act_query  = 1'b0;
        if (halted_reg)
        begin
            dec_status = ST_HALTED;
        end
        else
        begin
            case (func_reg)
                FN_TICK: act_tick = 1'b1;
                FN_SPAWN:
                begin
                    if (live_reg >= NCNT || lfree_reg >= NCNT)
                        dec_status = ST_FULL;
                    else
                        act_spawn = 1'b1;
                end
                FN_TERM:
                begin
                    if (tid_reg == '0)
                        act_halt = 1'b1;
                    else if (!exists)
                        dec_status = ST_NO_THR;
                    else
                        act_term = 1'b1;
                end
                FN_SUSPEND:
                begin
                    if (tid_reg == '0)
                        dec_status = ST_MAIN;
                    else if (!exists)
                        dec_status = ST_NO_THR;
                    else
                        act_susp = tid_mode != MODE_SLEEPING &&
                                   tid_mode != MODE_SUSPENDED;
                end
                FN_RESUME:
                begin
                    if (!exists)
                        dec_status = ST_NO_THR;
                    else
                        act_resume = tid_mode == MODE_SUSPENDED;
                end
                FN_SLEEP:
                begin
                    if (cur_reg == '0)
                        dec_status = ST_MAIN;
                    else if (nq_reg == '0)
                        dec_status = ST_BAD_CNT;
                    else
                        act_sleep = 1'b1;
                end
                FN_QUERY:
                begin
                    if (!exists)
                        dec_status = ST_NO_THR;
                    else
                        act_query = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                priority if (act_tick)
                    state_next = S_HO_INC;
                else if (act_spawn)
                    state_next = S_FREE;
                else if (act_term || act_susp || act_sleep)
                    state_next = S_RM_WAIT;
                else if (act_query)
                    state_next = S_QRD;
                else
                    state_next = S_DONE;
            end
            S_RM_WAIT:
            begin
                if (q_sts.done)
                    state_next = ho_pend_reg ? S_HO_INC : S_DONE;
            end
            S_FREE:
            begin
                if (!(lfree_reg < NCNT && valid_reg[lfree_reg[IDW-1:0]]))
                    state_next = S_DONE;
            end
            S_QRD:     state_next = S_DONE;
            S_HO_INC:  state_next = S_HO_SCAN;
            S_HO_SCAN:
            begin
                if (!scan_live)
                    state_next = S_HO_REQ;
            end
            S_HO_REQ:  state_next = S_HO_POP;
            S_HO_POP:  state_next = q_sts.empty ? S_HO_QRD : S_HO_POPW;
            S_HO_POPW:
            begin
                if (q_sts.done)
                    state_next = S_HO_QRD;
            end
            S_HO_QRD:  state_next = S_HO_QWR;
            S_HO_QWR:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        q_ctl       = '0;
        q_id        = tid_idx;
        tbl_rd_addr = '0;
        tbl_wr      = '0;
        tbl_wr_addr = cur_reg;
        tbl_q_wdata = '0;
        tbl_w_wdata = total_reg + 32'(nq_reg) + 32'd1;
        req.ready   = state_reg == S_IDLE;
        unique case (state_reg)
            S_DECODE:
            begin
                tbl_rd_addr = tid_idx;
                if (act_spawn)
                begin
                    q_ctl.push  = 1'b1;
                    q_id        = lfree_reg[IDW-1:0];
                    tbl_wr.q_we = 1'b1;
                    tbl_wr_addr = lfree_reg[IDW-1:0];
                end
                else if (act_resume)
                begin
                    q_ctl.push = 1'b1;
                end
                else if (act_term || act_susp)
                begin
                    q_ctl.remove = 1'b1;
                end
                else if (act_sleep)
                begin
                    q_ctl.remove = 1'b1;
                    q_id         = cur_reg;
                    tbl_wr.w_we  = 1'b1;
                end
            end
            S_HO_SCAN:
            begin
                tbl_rd_addr = scan_reg[IDW-1:0];
                q_ctl.push  = wake_hit;
                q_id        = cidx_reg;
            end
            S_HO_REQ:
            begin
                q_ctl.push = requeue_reg;
                q_id       = cur_reg;
            end
            S_HO_POP:  q_ctl.pop = !q_sts.empty;
            S_HO_QRD:  tbl_rd_addr = cur_reg;
            S_HO_QWR:
            begin
                tbl_wr.q_we = 1'b1;
                tbl_q_wdata = tbl_quanta + 32'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                valid_reg[i] <= i == 0;
                mode_reg[i]  <= (i == 0) ? MODE_RUNNING : MODE_READY;
            end
            cur_reg    <= '0;
            total_reg  <= 32'd1;
            lfree_reg  <= CW'(1);
            live_reg   <= CW'(1);
            halted_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_DECODE:
                begin
                    if (act_halt)
                        halted_reg <= 1'b1;
                    if (act_spawn)
                    begin
                        valid_reg[lfree_reg[IDW-1:0]] <= 1'b1;
                        mode_reg[lfree_reg[IDW-1:0]]  <= MODE_READY;
                        live_reg                      <= live_reg + CW'(1);
                    end
                    if (act_term)
                    begin
                        valid_reg[tid_idx] <= 1'b0;
                        mode_reg[tid_idx]  <= MODE_READY;
                        live_reg           <= live_reg - CW'(1);
                        if (XW'(lfree_reg) > tid_ext)
                            lfree_reg <= CW'(tid_idx);
                    end
                    if (act_susp)
                        mode_reg[tid_idx] <= MODE_SUSPENDED;
                    if (act_resume)
                        mode_reg[tid_idx] <= MODE_READY;
                    if (act_sleep)
                        mode_reg[cur_reg] <= MODE_SLEEPING;
                end
                S_FREE:
                begin
                    if (lfree_reg < NCNT && valid_reg[lfree_reg[IDW-1:0]])
                        lfree_reg <= lfree_reg + CW'(1);
                end
                S_HO_INC:  total_reg <= total_reg + 32'd1;
                S_HO_SCAN:
                begin
                    if (wake_hit)
                        mode_reg[cidx_reg] <= MODE_READY;
                end
                S_HO_REQ:
                begin
                    if (requeue_reg)
                        mode_reg[cur_reg] <= MODE_READY;
                end
                S_HO_POP:
                begin
                    if (q_sts.empty)
                        cur_reg <= '0;
                end
                S_HO_POPW:
                begin
                    if (q_sts.done)
                        cur_reg <= q_head;
                end
                S_HO_QRD:  mode_reg[cur_reg] <= MODE_RUNNING;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                func_reg <= req.func;
                tid_reg  <= req.thread_id;
                nq_reg   <= req.sleep_quanta;
            end
            S_DECODE:
            begin
                status_reg  <= dec_status;
                value_reg   <= act_spawn ? 32'(lfree_reg) : 32'd0;
                requeue_reg <= act_tick;
                ho_pend_reg <= act_sleep || ((act_term || act_susp) && tid_ext == cur_ext);
            end
            S_QRD:     value_reg <= tbl_quanta;
            S_HO_INC:
            begin
                scan_reg <= '0;
                cand_reg <= 1'b0;
            end
            S_HO_SCAN:
            begin
                cand_reg <= scan_live && valid_reg[scan_reg[IDW-1:0]] &&
                            mode_reg[scan_reg[IDW-1:0]] == MODE_SLEEPING;
                cidx_reg <= scan_reg[IDW-1:0];
                scan_reg <= scan_reg + CW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= status_reg;
                    out_value_reg  <= value_reg;
                    out_run_reg    <= cur_ext[3:0];
                    out_total_reg  <= total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.value          = out_value_reg;
    assign rsp.running_thread = out_run_reg;
    assign rsp.total_quanta   = out_total_reg;

    rrts_queue #(
        .MAX_THREADS (MAX_THREADS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .id    (q_id),
        .sts   (q_sts),
        .head  (q_head)
    );

    rrts_table #(
        .MAX_THREADS (MAX_THREADS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (tbl_rd_addr),
        .wr        (tbl_wr),
        .wr_addr   (tbl_wr_addr),
        .q_wdata   (tbl_q_wdata),
        .w_wdata   (tbl_w_wdata),
        .rd_quanta (tbl_quanta),
        .rd_wake   (tbl_wake)
    );

endmodule
